[rtl/core/windowed_busy_ratio_meter_top_defines.svh]
// assertion macros shared by the busy ratio meter checkers
`ifndef WINDOWED_BUSY_RATIO_METER_TOP_DEFINES_SVH
`define WINDOWED_BUSY_RATIO_METER_TOP_DEFINES_SVH

// implication on the next clock, masked while reset is asserted
`define WBRM_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("wbrm check failed");

// implication in the same clock, masked while reset is asserted
`define WBRM_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("wbrm check failed");

// implication on the next clock, active through reset
`define WBRM_ASSERT_RESET(name, ante, cons) \
    name: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("wbrm reset check failed");

`endif

[rtl/core/wbrm_pkg.sv]
// shared types and constants of the busy ratio meter
package wbrm_pkg;

    localparam int ACTION_W    = 2;
    localparam int MAXREC_W    = 6;
    localparam int WINDOW_W    = 32;
    localparam int PCT_W       = 7;
    localparam int M_TDATA_W   = 8;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 32;

    localparam logic [ACTION_W-1:0] ACT_SLEEP = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_WAKE  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_QUERY = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] REG_MAX_RECORDS  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LIMIT = 1'b1;

    localparam logic [MAXREC_W-1:0] RESET_MAX_RECORDS  = 6'd32;
    localparam logic [WINDOW_W-1:0] RESET_WINDOW_LIMIT = 32'd2000000;

    localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

endpackage

[rtl/core/wbrm_ram.sv]
// generic single write port ram with registered read
module wbrm_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/core/wbrm_alu.sv]
// shared add and subtract unit with borrow out
module wbrm_alu #(
    parameter int W = 40
) (
    input  wbrm_pkg::alu_op_t op,
    input  logic [W-1:0]      a,
    input  logic [W-1:0]      b,
    output logic [W-1:0]      y,
    output logic              borrow
);

    import wbrm_pkg::*;

    logic         is_sub;
    logic [W-1:0] b_eff;
    logic [W:0]   sum;

    assign is_sub = (op == ALU_SUB);
    assign b_eff  = is_sub ? ~b : b;
    assign sum    = {1'b0, a} + {1'b0, b_eff} + {{W{1'b0}}, is_sub};
    assign y      = sum[W-1:0];
    // a - b underflows when the carry out of a + ~b + 1 is clear
    assign borrow = is_sub & ~sum[W];

endmodule

[rtl/core/windowed_busy_ratio_meter_top.sv]
// top level of the sliding window busy ratio meter
// sleep and wake events pass through the push state before the input is ready again
// a query opens, walks the records, totals, evicts, scales and divides, then
// waits for the result register if it is busy; all arithmetic shares one add/sub unit
// the query divider resolves one quotient bit per cycle, 7 bits in total
// aresetn is synchronous active low; the record ram is not cleared, only its count and oldest pointer
module windowed_busy_ratio_meter_top #(
    parameter int RECORD_DEPTH = 32,
    parameter int STAMP_BITS   = 32
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    // input stream
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    // s_tdata: action [1:0], now [STAMP_BITS+1:2], zero pad above
    input  logic [((STAMP_BITS + 9) / 8) * 8 - 1:0]   s_tdata,
    // result stream
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    // m_tdata: load_percent [6:0], zero pad above
    output logic [wbrm_pkg::M_TDATA_W-1:0]            m_tdata,
    // configuration write channel
    input  logic                                      cfg_valid,
    output logic                                      cfg_ready,
    input  logic [wbrm_pkg::CFG_INDEX_W-1:0]          cfg_index,
    input  logic [wbrm_pkg::CFG_DATA_W-1:0]           cfg_data
);

    import wbrm_pkg::*;

    // widths derived from the parameters
    localparam int IDX_W = $clog2(RECORD_DEPTH);
    localparam int CNT_W = $clog2(RECORD_DEPTH + 1);
    localparam int REC_W = STAMP_BITS + 1;
    // sum of all records plus the open interval
    localparam int SUM_W = STAMP_BITS + CNT_W;
    // the datapath must hold busy*100 and the window limit compare
    localparam int ACC_W = (SUM_W + PCT_W > WINDOW_W + 1) ? SUM_W + PCT_W : WINDOW_W + 1;
    // width for comparing the record count with the limit
    localparam int LIM_W = (CNT_W > MAXREC_W) ? CNT_W : MAXREC_W;

    // sequencer states
    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_EV_PUSH = 4'd1;
    localparam logic [3:0] ST_Q_OPEN  = 4'd2;
    localparam logic [3:0] ST_Q_WALK  = 4'd3;
    localparam logic [3:0] ST_Q_TOTAL = 4'd4;
    localparam logic [3:0] ST_Q_CHK   = 4'd5;
    localparam logic [3:0] ST_Q_EVSUB = 4'd6;
    localparam logic [3:0] ST_Q_EVBSY = 4'd7;
    localparam logic [3:0] ST_Q_MUL1  = 4'd8;
    localparam logic [3:0] ST_Q_MUL2  = 4'd9;
    localparam logic [3:0] ST_Q_DIV   = 4'd10;
    localparam logic [3:0] ST_Q_OUT   = 4'd11;

    // control state
    logic [3:0]            state_reg, state_next;
    logic [MAXREC_W-1:0]   max_records_reg, max_records_next;
    logic [WINDOW_W-1:0]   window_limit_reg, window_limit_next;
    logic [IDX_W-1:0]      oldest_reg, oldest_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  sleeping_reg, sleeping_next;
    logic [STAMP_BITS-1:0] sleep_stamp_reg, sleep_stamp_next;
    logic [STAMP_BITS-1:0] wake_stamp_reg, wake_stamp_next;
    logic                  rd_pend_reg, rd_pend_next;
    logic                  m_tvalid_reg, m_tvalid_next;

    // working registers
    logic                  ev_sleep_reg, ev_sleep_next;
    logic [STAMP_BITS-1:0] now_reg, now_next;
    logic [ACC_W-1:0]      busy_reg, busy_next;
    logic [ACC_W-1:0]      total_reg, total_next;
    logic [IDX_W-1:0]      walk_ptr_reg, walk_ptr_next;
    logic [CNT_W-1:0]      walk_left_reg, walk_left_next;
    logic [2:0]            bit_reg, bit_next;
    logic [PCT_W-1:0]      quot_reg, quot_next;
    logic [PCT_W-1:0]      pct_reg, pct_next;

    // shared unit
    alu_op_t               alu_op;
    logic [ACC_W-1:0]      alu_a, alu_b, alu_y;
    logic                  alu_borrow;

    // record ram
    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr, ram_raddr;
    logic [REC_W-1:0]      ram_wdata, ram_rdata;
    logic                  rd_busy;
    logic [STAMP_BITS-1:0] rd_ticks;

    // limit and slot helpers
    logic [LIM_W-1:0]      count_ext, lim;
    logic                  at_limit;
    logic [IDX_W:0]        slot_wide;
    logic [IDX_W-1:0]      slot;
    logic [IDX_W-1:0]      oldest_inc, walk_ptr_inc;
    logic                  s_accept;
    logic [ACTION_W-1:0]   s_action;
    logic [STAMP_BITS-1:0] s_now;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid & s_tready;
    assign s_action  = s_tdata[ACTION_W-1:0];
    assign s_now     = s_tdata[ACTION_W +: STAMP_BITS];
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {{(M_TDATA_W - PCT_W){1'b0}}, pct_reg};

    assign rd_busy  = ram_rdata[STAMP_BITS];
    assign rd_ticks = ram_rdata[STAMP_BITS-1:0];

    // effective count limit is min(max_records, depth)
    always_comb begin
        count_ext = LIM_W'(count_reg);
        if (LIM_W'(max_records_reg) > LIM_W'(RECORD_DEPTH)) begin
            lim = LIM_W'(RECORD_DEPTH);
        end else begin
            lim = LIM_W'(max_records_reg);
        end
        // appending would pass the limit
        at_limit = (count_ext >= lim);
    end

    // next free slot; dropping the oldest first leaves the slot unchanged
    always_comb begin
        slot_wide = {1'b0, oldest_reg} + (IDX_W + 1)'(count_reg);
        if (slot_wide >= (IDX_W + 1)'(RECORD_DEPTH)) begin
            slot = IDX_W'(slot_wide - (IDX_W + 1)'(RECORD_DEPTH));
        end else begin
            slot = IDX_W'(slot_wide);
        end
    end

    assign oldest_inc   = (oldest_reg == IDX_W'(RECORD_DEPTH - 1)) ? '0 : oldest_reg + 1'b1;
    assign walk_ptr_inc = (walk_ptr_reg == IDX_W'(RECORD_DEPTH - 1)) ? '0 : walk_ptr_reg + 1'b1;

    // the walk reads ahead by pointer, everything else reads the oldest record
    assign ram_raddr = (state_reg == ST_Q_WALK) ? walk_ptr_reg : oldest_reg;
    assign ram_waddr = slot;

    // operand selection for the shared unit
    always_comb begin
        alu_op = ALU_ADD;
        alu_a  = '0;
        alu_b  = '0;
        unique case (state_reg)
            ST_EV_PUSH: begin
                // closed interval length, wraps modulo the stamp width
                alu_op = ALU_SUB;
                alu_a  = ACC_W'(now_reg);
                alu_b  = ev_sleep_reg ? ACC_W'(wake_stamp_reg) : ACC_W'(sleep_stamp_reg);
            end
            ST_Q_OPEN: begin
                alu_op = ALU_SUB;
                alu_a  = ACC_W'(now_reg);
                alu_b  = sleeping_reg ? ACC_W'(sleep_stamp_reg) : ACC_W'(wake_stamp_reg);
            end
            ST_Q_WALK: begin
                // idle ticks accumulate in total_reg until the total step
                alu_a = rd_busy ? busy_reg : total_reg;
                alu_b = ACC_W'(rd_ticks);
            end
            ST_Q_TOTAL: begin
                alu_a = busy_reg;
                alu_b = total_reg;
            end
            ST_Q_CHK: begin
                // borrow means total is over the window limit
                alu_op = ALU_SUB;
                alu_a  = ACC_W'(window_limit_reg);
                alu_b  = total_reg;
            end
            ST_Q_EVSUB: begin
                alu_op = ALU_SUB;
                alu_a  = total_reg;
                alu_b  = ACC_W'(rd_ticks);
            end
            ST_Q_EVBSY: begin
                alu_op = ALU_SUB;
                alu_a  = busy_reg;
                alu_b  = ACC_W'(rd_ticks);
            end
            ST_Q_MUL1, ST_Q_MUL2: begin
                // x*5 as (x<<2)+x, applied twice, then <<2 gives x*100
                alu_a = busy_reg << 2;
                alu_b = busy_reg;
            end
            ST_Q_DIV: begin
                // restoring division, one quotient bit per pass
                alu_op = ALU_SUB;
                alu_a  = busy_reg;
                alu_b  = total_reg << bit_reg;
            end
            default: begin
                alu_op = ALU_ADD;
            end
        endcase
    end

    wbrm_alu #(
        .W(ACC_W)
    ) u_alu (
        .op     (alu_op),
        .a      (alu_a),
        .b      (alu_b),
        .y      (alu_y),
        .borrow (alu_borrow)
    );

    assign ram_wdata = {ev_sleep_reg, alu_y[STAMP_BITS-1:0]};
    // with a limit of zero the new record is dropped at once
    assign ram_we    = (state_reg == ST_EV_PUSH) && !(at_limit && (count_reg == '0));

    wbrm_ram #(
        .WIDTH(REC_W),
        .DEPTH(RECORD_DEPTH)
    ) u_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // sequencer
    always_comb begin
        state_next        = state_reg;
        max_records_next  = max_records_reg;
        window_limit_next = window_limit_reg;
        oldest_next       = oldest_reg;
        count_next        = count_reg;
        sleeping_next     = sleeping_reg;
        sleep_stamp_next  = sleep_stamp_reg;
        wake_stamp_next   = wake_stamp_reg;
        rd_pend_next      = 1'b0;
        ev_sleep_next     = ev_sleep_reg;
        now_next          = now_reg;
        busy_next         = busy_reg;
        total_next        = total_reg;
        walk_ptr_next     = walk_ptr_reg;
        walk_left_next    = walk_left_reg;
        bit_next          = bit_reg;
        quot_next         = quot_reg;
        pct_next          = pct_reg;
        m_tvalid_next     = m_tvalid_reg & ~m_tready;

        // the user must send register writes only while the block is idle; the block does not enforce it
        if (cfg_valid && cfg_ready) begin
            if (cfg_index == REG_MAX_RECORDS) begin
                max_records_next = cfg_data[MAXREC_W-1:0];
            end else begin
                window_limit_next = cfg_data[WINDOW_W-1:0];
            end
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    now_next = s_now;
                    priority if (s_action == ACT_SLEEP) begin
                        ev_sleep_next = 1'b1;
                        state_next    = ST_EV_PUSH;
                    end else if (s_action == ACT_WAKE) begin
                        ev_sleep_next = 1'b0;
                        state_next    = ST_EV_PUSH;
                    end else if (s_action == ACT_QUERY) begin
                        state_next = ST_Q_OPEN;
                    end else begin
                        // unknown action transaction, nothing to do
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_EV_PUSH: begin
                sleeping_next = ev_sleep_reg;
                if (ev_sleep_reg) begin
                    sleep_stamp_next = now_reg;
                end else begin
                    wake_stamp_next = now_reg;
                end
                if (at_limit) begin
                    // drop one and add one, count unchanged
                    if (count_reg != '0) begin
                        oldest_next = oldest_inc;
                    end
                end else begin
                    count_next = count_reg + 1'b1;
                end
                state_next = ST_IDLE;
            end
            ST_Q_OPEN: begin
                // open interval seeds the matching sum
                if (sleeping_reg) begin
                    busy_next  = '0;
                    total_next = ACC_W'(alu_y[STAMP_BITS-1:0]);
                end else begin
                    busy_next  = ACC_W'(alu_y[STAMP_BITS-1:0]);
                    total_next = '0;
                end
                walk_ptr_next  = oldest_reg;
                walk_left_next = count_reg;
                state_next     = ST_Q_WALK;
            end
            ST_Q_WALK: begin
                // one read issued and one record summed per cycle
                if (walk_left_reg != '0) begin
                    rd_pend_next   = 1'b1;
                    walk_ptr_next  = walk_ptr_inc;
                    walk_left_next = walk_left_reg - 1'b1;
                end
                if (rd_pend_reg) begin
                    if (rd_busy) begin
                        busy_next = alu_y;
                    end else begin
                        total_next = alu_y;
                    end
                end
                if ((walk_left_reg == '0) && !rd_pend_reg) begin
                    state_next = ST_Q_TOTAL;
                end
            end
            ST_Q_TOTAL: begin
                total_next = alu_y;
                state_next = ST_Q_CHK;
            end
            ST_Q_CHK: begin
                priority if ((count_reg != '0) && (alu_borrow || (count_ext > lim))) begin
                    state_next = ST_Q_EVSUB;
                end else if (total_reg == '0) begin
                    quot_next  = '0;
                    state_next = ST_Q_OUT;
                end else begin
                    state_next = ST_Q_MUL1;
                end
            end
            ST_Q_EVSUB: begin
                total_next = alu_y;
                state_next = ST_Q_EVBSY;
            end
            ST_Q_EVBSY: begin
                if (rd_busy) begin
                    busy_next = alu_y;
                end
                oldest_next = oldest_inc;
                count_next  = count_reg - 1'b1;
                state_next  = ST_Q_CHK;
            end
            ST_Q_MUL1: begin
                busy_next  = alu_y;
                state_next = ST_Q_MUL2;
            end
            ST_Q_MUL2: begin
                busy_next  = alu_y << 2;
                bit_next   = 3'd6;
                quot_next  = '0;
                state_next = ST_Q_DIV;
            end
            ST_Q_DIV: begin
                if (!alu_borrow) begin
                    busy_next = alu_y;
                end
                quot_next = {quot_reg[PCT_W-2:0], ~alu_borrow};
                if (bit_reg == 3'd0) begin
                    state_next = ST_Q_OUT;
                end else begin
                    bit_next = bit_reg - 1'b1;
                end
            end
            ST_Q_OUT: begin
                // load the result register once it is free
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    pct_next      = quot_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            max_records_reg  <= RESET_MAX_RECORDS;
            window_limit_reg <= RESET_WINDOW_LIMIT;
            oldest_reg       <= '0;
            count_reg        <= '0;
            sleeping_reg     <= 1'b1;
            sleep_stamp_reg  <= '0;
            wake_stamp_reg   <= '0;
            rd_pend_reg      <= 1'b0;
            m_tvalid_reg     <= 1'b0;
        end else begin
            state_reg        <= state_next;
            max_records_reg  <= max_records_next;
            window_limit_reg <= window_limit_next;
            oldest_reg       <= oldest_next;
            count_reg        <= count_next;
            sleeping_reg     <= sleeping_next;
            sleep_stamp_reg  <= sleep_stamp_next;
            wake_stamp_reg   <= wake_stamp_next;
            rd_pend_reg      <= rd_pend_next;
            m_tvalid_reg     <= m_tvalid_next;
        end
    end

    // working registers, no reset needed
    always_ff @(posedge aclk) begin
        ev_sleep_reg  <= ev_sleep_next;
        now_reg       <= now_next;
        busy_reg      <= busy_next;
        total_reg     <= total_next;
        walk_ptr_reg  <= walk_ptr_next;
        walk_left_reg <= walk_left_next;
        bit_reg       <= bit_next;
        quot_reg      <= quot_next;
        pct_reg       <= pct_next;
    end

endmodule

[rtl/core/wbrm_checker.sv]
// port level checks of the busy ratio meter and their bind
`include "windowed_busy_ratio_meter_top_defines.svh"

module wbrm_checker #(
    parameter int STAMP_BITS = 32
) (
    input logic                                    aclk,
    input logic                                    aresetn,
    input logic                                    s_tvalid,
    input logic                                    s_tready,
    input logic [((STAMP_BITS + 9) / 8) * 8 - 1:0] s_tdata,
    input logic                                    m_tvalid,
    input logic                                    m_tready,
    input logic [wbrm_pkg::M_TDATA_W-1:0]          m_tdata
);

    import wbrm_pkg::*;

    logic                s_hs;
    logic [ACTION_W-1:0] s_act;

    assign s_hs  = s_tvalid && s_tready;
    assign s_act = s_tdata[ACTION_W-1:0];

    // a stalled result holds
    `WBRM_ASSERT_NEXT(a_result_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    // percentage never exceeds one hundred
    `WBRM_ASSERT_NOW(a_result_range, m_tvalid, m_tdata[PCT_W-1:0] <= PCT_MAX)
    // events and unknown actions never raise a result
    `WBRM_ASSERT_NEXT(a_event_silent, s_hs && (s_act != ACT_QUERY) && !m_tvalid, !m_tvalid)
    // a query occupies the sequencer
    `WBRM_ASSERT_NEXT(a_query_busy, s_hs && (s_act == ACT_QUERY), !s_tready)
    // ready right after reset
    `WBRM_ASSERT_RESET(a_reset_ready, !aresetn, s_tready)

endmodule

bind windowed_busy_ratio_meter_top wbrm_checker #(
    .STAMP_BITS(STAMP_BITS)
) u_wbrm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
